// ----- hdl/ami_pkg.sv -----
//------------------------------------------------------------------------------
// ami_pkg
// Shared constants, types and fixed-point helpers for the affine inverse block.
//------------------------------------------------------------------------------
`default_nettype none

package ami_pkg;

  localparam int WordBits = 32;
  localparam int FracBits = 16;
  localparam int ThrBits  = 17;
  localparam int ProdBits = 2 * WordBits;

  typedef logic signed [WordBits-1:0] word_t;

  localparam logic signed [WordBits+2:0] WordMaxP = (WordBits+3)'((64'sd1 <<< (WordBits-1)) - 1);
  localparam logic signed [WordBits+2:0] WordMaxN = -(WordBits+3)'(64'sd1 <<< (WordBits-1));

  // Saturate a three-bits-wider signed sum to one word.
  function automatic word_t sat_w(input logic signed [WordBits+2:0] v);
    word_t r;
    if (v > WordMaxP) begin
      r = WordMaxP[WordBits-1:0];
    end else if (v < WordMaxN) begin
      r = WordMaxN[WordBits-1:0];
    end else begin
      r = v[WordBits-1:0];
    end
    return r;
  endfunction

  // Round a full signed product half away from zero at the binary point, then saturate.
  function automatic word_t fround(input logic signed [ProdBits-1:0] p);
    logic neg;
    logic [ProdBits-1:0] m;
    logic [ProdBits:0] s;
    logic [ProdBits-FracBits:0] q;
    logic [WordBits-1:0] capv;
    word_t r;
    neg = p[ProdBits-1];
    m = neg ? (~p + 1'b1) : p;
    s = {1'b0, m} + (ProdBits+1)'(64'd1 << (FracBits-1));
    q = s[ProdBits:FracBits];
    capv = neg ? WordMaxN[WordBits-1:0] : WordMaxP[WordBits-1:0];
    if (q > (ProdBits-FracBits+1)'(capv)) begin
      q = (ProdBits-FracBits+1)'(capv);
    end
    r = neg ? word_t'(~q[WordBits-1:0] + 1'b1) : word_t'(q[WordBits-1:0]);
    return r;
  endfunction

  typedef struct packed {
    logic  vld;
    logic  sing;
    word_t [8:0] inv;
    word_t [2:0] t;
  } inv_t;

endpackage

`default_nettype wire

// ----- hdl/ami_recip.sv -----
//------------------------------------------------------------------------------
// ami_recip
// Pipelined restoring divider: round(2^(2F) / d), one quotient bit per stage.
//------------------------------------------------------------------------------
`default_nettype none

module ami_recip
  import ami_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic [WordBits:0]    d_i,
  output logic      [WordBits+1:0]  q_o
);

  localparam int NumBits = 2 * FracBits + 2;
  localparam int Stages  = NumBits;
  localparam int RemBits = WordBits + 2;

  // The numerator is 2^(2F+1) + d; quotient halved gives rounding half away.
  logic [NumBits-1:0]    num_q [Stages+1];
  logic [RemBits-1:0]    rem_q [Stages+1];
  logic [NumBits-1:0]    quo_q [Stages+1];
  logic [WordBits:0]     den_q [Stages+1];

  always_comb begin
    num_q[0] = NumBits'(64'd1 << (2*FracBits+1)) + NumBits'(d_i);
    rem_q[0] = '0;
    quo_q[0] = '0;
    den_q[0] = d_i;
  end

  for (genvar g = 0; g < Stages; g++) begin : g_stage
    logic [RemBits-1:0] r_sh;
    logic [RemBits:0]   diff;
    always_comb begin
      r_sh = {rem_q[g][RemBits-2:0], num_q[g][NumBits-1-g]};
      diff = {1'b0, r_sh} - {1'b0, RemBits'(den_q[g])};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[g+1] <= num_q[g];
        den_q[g+1] <= den_q[g];
        rem_q[g+1] <= diff[RemBits] ? r_sh : diff[RemBits-1:0];
        quo_q[g+1] <= {quo_q[g][NumBits-2:0], ~diff[RemBits]};
      end
    end
  end

  logic [NumBits-1:0] half;
  assign half = quo_q[Stages] >> 1;
  assign q_o = (half > NumBits'({2'b00, {WordBits{1'b1}}})) ? {2'b00, {WordBits{1'b1}}}
             : half[WordBits+1:0];

endmodule

`default_nettype wire

// ----- hdl/ami_core.sv -----
//------------------------------------------------------------------------------
// ami_core
// Cofactor, determinant, reciprocal and inverse pipeline with a global enable.
//------------------------------------------------------------------------------
`default_nettype none

module ami_core
  import ami_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               vld_i,
  input  wire word_t [8:0]        a_i,
  input  wire word_t [2:0]        t_i,
  input  wire logic [ThrBits-1:0] thr_i,
  output inv_t                    res_o
);

  localparam int RecLat = 2 * FracBits + 2;
  localparam int Lat    = RecLat + 2;

  typedef logic signed [WordBits+2:0] wide_t;

  // Stage 1: cofactor products.
  logic signed [ProdBits-1:0] cp_q [18];
  word_t [8:0] a1_q;
  word_t [2:0] t1_q;
  // index pairs for k[i][j] = p*q - r*s
  localparam int Ci [36] = '{4,8,5,7, 1,8,2,7, 1,5,2,4, 3,8,5,6, 0,8,2,6,
                             0,5,2,3, 3,7,4,6, 0,7,1,6, 0,4,1,3};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) begin
        cp_q[2*k]   <= ProdBits'(a_i[Ci[4*k]])   * ProdBits'(a_i[Ci[4*k+1]]);
        cp_q[2*k+1] <= ProdBits'(a_i[Ci[4*k+2]]) * ProdBits'(a_i[Ci[4*k+3]]);
      end
      a1_q <= a_i;
      t1_q <= t_i;
    end
  end

  // Stage 2: cofactors.
  word_t [8:0] k2_q;
  word_t [8:0] a2_q;
  word_t [2:0] t2_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) begin
        k2_q[k] <= sat_w(wide_t'(fround(cp_q[2*k])) - wide_t'(fround(cp_q[2*k+1])));
      end
      a2_q <= a1_q;
      t2_q <= t1_q;
    end
  end

  // Stage 3: determinant products.
  logic signed [ProdBits-1:0] dp_q [3];
  word_t [8:0] k3_q;
  word_t [2:0] t3_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dp_q[0] <= ProdBits'(a2_q[0]) * ProdBits'(k2_q[0]);
      dp_q[1] <= ProdBits'(a2_q[1]) * ProdBits'(k2_q[3]);
      dp_q[2] <= ProdBits'(a2_q[2]) * ProdBits'(k2_q[6]);
      k3_q <= k2_q;
      t3_q <= t2_q;
    end
  end

  // Stage 4: determinant, singular test, signed adjugate.
  word_t det4_q;
  logic [WordBits:0] mag4_q;
  logic sing4_q;
  word_t [8:0] e4_q;
  word_t [2:0] t4_q;
  word_t det_c;
  logic [WordBits:0] mag_c;
  always_comb begin
    det_c = sat_w(wide_t'(fround(dp_q[0])) - wide_t'(fround(dp_q[1]))
                  + wide_t'(fround(dp_q[2])));
    mag_c = det_c[WordBits-1] ? ((WordBits+1)'(0) - {det_c[WordBits-1], det_c})
                              : {1'b0, det_c};
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det4_q  <= det_c;
      mag4_q  <= mag_c;
      sing4_q <= (mag_c == '0) || (mag_c < (WordBits+1)'(thr_i));
      for (int k = 0; k < 9; k++) begin
        e4_q[k] <= (((k / 3) + (k % 3)) % 2 == 1) ? sat_w(-wide_t'(k3_q[k])) : k3_q[k];
      end
      t4_q <= t3_q;
    end
  end

  // Reciprocal pipeline; adjugate and flags ride alongside in delay lines.
  logic [WordBits+1:0] q_r;
  ami_recip u_recip (
    .clk_i (clk_i),
    .en_i  (en_i),
    .d_i   (mag4_q | {{WordBits{1'b0}}, sing4_q}),
    .q_o   (q_r)
  );

  word_t [8:0] ed_q [RecLat+1];
  word_t [2:0] td_q [RecLat+1];
  logic        nd_q [RecLat+1];
  logic        sd_q [RecLat+1];
  always_comb begin
    ed_q[0] = e4_q;
    td_q[0] = t4_q;
    nd_q[0] = det4_q[WordBits-1];
    sd_q[0] = sing4_q;
  end
  for (genvar g = 0; g < RecLat; g++) begin : g_dly
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ed_q[g+1] <= ed_q[g];
        td_q[g+1] <= td_q[g];
        nd_q[g+1] <= nd_q[g];
        sd_q[g+1] <= sd_q[g];
      end
    end
  end

  // Signed reciprocal, then inverse products.
  word_t rc_c;
  always_comb begin
    if (nd_q[RecLat]) begin
      rc_c = (q_r > (WordBits+2)'(WordMaxN[WordBits-1:0]))
             ? WordMaxN[WordBits-1:0] : word_t'(~q_r[WordBits-1:0] + 1'b1);
    end else begin
      rc_c = (q_r > (WordBits+2)'(WordMaxP[WordBits-1:0]))
             ? WordMaxP[WordBits-1:0] : word_t'(q_r[WordBits-1:0]);
    end
  end

  logic signed [ProdBits-1:0] ip_q [9];
  word_t [2:0] t5_q;
  logic s5_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) begin
        ip_q[k] <= ProdBits'(rc_c) * ProdBits'(ed_q[RecLat][k]);
      end
      t5_q <= td_q[RecLat];
      s5_q <= sd_q[RecLat];
    end
  end

  word_t [8:0] inv6_q;
  word_t [2:0] t6_q;
  logic s6_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) begin
        inv6_q[k] <= fround(ip_q[k]);
      end
      t6_q <= t5_q;
      s6_q <= s5_q;
    end
  end

  // Translation products.
  logic signed [ProdBits-1:0] tp_q [9];
  word_t [8:0] inv7_q;
  logic s7_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          tp_q[3*j+i] <= ProdBits'(t6_q[i]) * ProdBits'(inv6_q[3*i+j]);
        end
      end
      inv7_q <= inv6_q;
      s7_q <= s6_q;
    end
  end

  // Final sums and zeroing of singular results.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o.sing <= s7_q;
      for (int k = 0; k < 9; k++) begin
        res_o.inv[k] <= s7_q ? '0 : inv7_q[k];
      end
      for (int j = 0; j < 3; j++) begin
        res_o.t[j] <= s7_q ? '0 : sat_w(-(wide_t'(fround(tp_q[3*j]))
                                  + wide_t'(fround(tp_q[3*j+1]))
                                  + wide_t'(fround(tp_q[3*j+2]))));
      end
    end
  end

  // Valid bits, reset to empty.
  logic [Lat+5:0] v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[Lat+4:0], vld_i};
    end
  end
  assign res_o.vld = v_q[Lat+5];

endmodule

`default_nettype wire

// ----- hdl/affine_matrix_inverse.sv -----
//------------------------------------------------------------------------------
// affine_matrix_inverse
// Inverse of an affine transform in signed Q16.16, streamed out as four rows.
//------------------------------------------------------------------------------
// Usage: the input channel (in_valid_i/in_ready_o) carries one matrix word: the
// 3x3 linear part and the translation row. The output channel
// (out_valid_o/out_ready_i) returns four row words, rows 0..2 of the inverse
// linear part and row 3 the inverse translation, with last_row_o on row 3.
// A singular determinant gives singular_o on all four rows and zero elements.
// Data pass the cofactor stages, the 34-stage reciprocal divider and the
// inverse stages. The row serializer limits throughput: the pipeline advances
// only when its tail slot is free or the last row is being taken, so a
// stalled receiver holds everything and nothing is dropped.
// Reset empties the pipeline and loads the threshold register thr_q with 7.
//------------------------------------------------------------------------------
`default_nettype none

module affine_matrix_inverse
  import ami_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [ThrBits-1:0] cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire word_t              a00_i, a01_i, a02_i,
  input  wire word_t              a10_i, a11_i, a12_i,
  input  wire word_t              a20_i, a21_i, a22_i,
  input  wire word_t              tx_i, ty_i, tz_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              row_index_o,
  output word_t                   col_x_o,
  output word_t                   col_y_o,
  output word_t                   col_z_o,
  output logic                    singular_o,
  output logic                    last_row_o
);

  logic [ThrBits-1:0] thr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrBits'(7);
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Serializer holding one result; the pipeline advances when it can take one.
  inv_t  res;
  inv_t  hold_q;
  logic  full_q;
  logic [1:0] row_q;
  logic  en;
  logic  done;

  assign done = full_q && out_ready_i && (row_q == 2'd3);
  assign en   = !full_q || done;
  assign in_ready_o = en;

  ami_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_valid_i),
    .a_i    ({a22_i, a21_i, a20_i, a12_i, a11_i, a10_i, a02_i, a01_i, a00_i}),
    .t_i    ({tz_i, ty_i, tx_i}),
    .thr_i  (thr_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      row_q  <= 2'd0;
    end else begin
      if (en) begin
        full_q <= res.vld;
        row_q  <= 2'd0;
      end else if (out_ready_i) begin
        row_q <= row_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && res.vld) begin
      hold_q <= res;
    end
  end

  always_comb begin
    out_valid_o = full_q;
    row_index_o = row_q;
    singular_o  = hold_q.sing;
    last_row_o  = (row_q == 2'd3);
    case (row_q)
      2'd3: begin
        col_x_o = hold_q.t[0];
        col_y_o = hold_q.t[1];
        col_z_o = hold_q.t[2];
      end
      default: begin
        col_x_o = hold_q.inv[3*row_q];
        col_y_o = hold_q.inv[3*row_q+1];
        col_z_o = hold_q.inv[3*row_q+2];
      end
    endcase
  end

  a_row_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> row_index_o == 2'd0) else $error("row not restarted");
  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_row_o)
      |=> out_valid_o && (row_index_o == $past(row_index_o) + 2'd1))
    else $error("word dropped mid-matrix");
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && singular_o) |-> (col_x_o == '0 && col_y_o == '0 && col_z_o == '0))
    else $error("singular row not zero");

endmodule

`default_nettype wire

// ----- sim/tb_affine_matrix_inverse.sv -----
//------------------------------------------------------------------------------
// tb_affine_matrix_inverse
// Self-checking testbench for the affine inverse block. Each matrix word sent
// in is run through an in-bench fixed-point model of the inverse. The four
// expected rows are queued, and every row word that comes out is compared
// against them field by field. Directed cases, threshold settings, back
// pressure, sender pauses and random runs at several thresholds are covered.
//------------------------------------------------------------------------------
`default_nettype none

module tb_affine_matrix_inverse
  import ami_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint QOne     = 64'sd65536;
  localparam longint PosCap   = 64'sd2147483647;
  localparam longint NegCap   = 64'sd2147483648;
  localparam int     WdogMax  = 5000;
  localparam int     HoldLen  = 300;
  localparam int     Settle   = 60;

  typedef struct {
    word_t a[9];
    word_t t[3];
  } matrix_t;

  typedef struct {
    logic [1:0] row;
    word_t      x, y, z;
    logic       sing;
    logic       last;
  } row_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [ThrBits-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  word_t m_a[9];
  word_t m_t[3];
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] row_index;
  word_t col_x, col_y, col_z;
  logic singular, last_row;

  row_word_t rows_due[$];
  logic [ThrBits-1:0] thr_model = 17'd7;
  int errors = 0;
  bit no_idle = 1'b0;
  bit hold_go = 1'b0;
  int hold_cnt = 0;
  int wdog = 0;

  initial begin
    for (int i = 0; i < 9; i++) m_a[i] = '0;
    for (int i = 0; i < 3; i++) m_t[i] = '0;
  end

  always #5 clk_i = ~clk_i;

  affine_matrix_inverse u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .a00_i(m_a[0]), .a01_i(m_a[1]), .a02_i(m_a[2]),
    .a10_i(m_a[3]), .a11_i(m_a[4]), .a12_i(m_a[5]),
    .a20_i(m_a[6]), .a21_i(m_a[7]), .a22_i(m_a[8]),
    .tx_i(m_t[0]), .ty_i(m_t[1]), .tz_i(m_t[2]),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .row_index_o(row_index),
    .col_x_o    (col_x),
    .col_y_o    (col_y),
    .col_z_o    (col_z),
    .singular_o (singular),
    .last_row_o (last_row)
  );

  // ---------------------------------------------------------------- fixed point
  function automatic longint clamp_word(longint v);
    if (v > PosCap) return PosCap;
    if (v < -NegCap) return -NegCap;
    return v;
  endfunction

  function automatic longint cap_mag(bit neg, longint m);
    longint c;
    c = neg ? NegCap : PosCap;
    if (m > c) m = c;
    return neg ? -m : m;
  endfunction

  function automatic longint qmul(longint a, longint b);
    bit neg;
    longint ua, ub, p;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    p = (ua * ub + 64'sd32768) >>> 16;
    return cap_mag(neg, p);
  endfunction

  function automatic longint minor2(longint p, longint q, longint r, longint s);
    return clamp_word(qmul(p, q) - qmul(r, s));
  endfunction

  // Expected inverse rows for one matrix word.
  task automatic predict_inverse(input matrix_t m);
    longint a[3][3], k[3][3], inv[3][3], tr[3];
    longint det, ud, q, rc, e;
    bit sing;
    row_word_t r;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) a[i][j] = longint'(m.a[i*3+j]);
    k[0][0] = minor2(a[1][1], a[2][2], a[1][2], a[2][1]);
    k[0][1] = minor2(a[0][1], a[2][2], a[0][2], a[2][1]);
    k[0][2] = minor2(a[0][1], a[1][2], a[0][2], a[1][1]);
    k[1][0] = minor2(a[1][0], a[2][2], a[1][2], a[2][0]);
    k[1][1] = minor2(a[0][0], a[2][2], a[0][2], a[2][0]);
    k[1][2] = minor2(a[0][0], a[1][2], a[0][2], a[1][0]);
    k[2][0] = minor2(a[1][0], a[2][1], a[1][1], a[2][0]);
    k[2][1] = minor2(a[0][0], a[2][1], a[0][1], a[2][0]);
    k[2][2] = minor2(a[0][0], a[1][1], a[0][1], a[1][0]);
    det = clamp_word(qmul(a[0][0], k[0][0]) - qmul(a[0][1], k[1][0])
                     + qmul(a[0][2], k[2][0]));
    ud = (det < 0) ? -det : det;
    sing = (ud == 0) || (ud < longint'(thr_model));
    for (int i = 0; i < 3; i++) begin
      inv[i] = '{0, 0, 0};
      tr[i] = 0;
    end
    if (!sing) begin
      q = ((64'sd1 <<< 32) + ud / 2) / ud;
      rc = cap_mag(det < 0, q);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          e = ((i + j) & 1) ? clamp_word(-k[i][j]) : k[i][j];
          inv[i][j] = qmul(rc, e);
        end
      for (int j = 0; j < 3; j++)
        tr[j] = clamp_word(-(qmul(longint'(m.t[0]), inv[0][j])
                             + qmul(longint'(m.t[1]), inv[1][j])
                             + qmul(longint'(m.t[2]), inv[2][j])));
    end
    for (int i = 0; i < 4; i++) begin
      r.row  = 2'(i);
      r.x    = word_t'((i < 3) ? inv[i][0] : tr[0]);
      r.y    = word_t'((i < 3) ? inv[i][1] : tr[1]);
      r.z    = word_t'((i < 3) ? inv[i][2] : tr[2]);
      r.sing = sing;
      r.last = (i == 3);
      rows_due.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------- drivers
  task automatic send_matrix(input matrix_t m);
    if (!no_idle && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    m_a <= m.a;
    m_t <= m.t;
    do @(posedge clk_i); while (!in_ready);
    predict_inverse(m);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (rows_due.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic set_threshold(input logic [ThrBits-1:0] v);
    stop_sending();
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    thr_model = v;
  endtask

  function automatic matrix_t diag_matrix(word_t d0, word_t d1, word_t d2,
                                          word_t tx, word_t ty, word_t tz);
    matrix_t m;
    for (int i = 0; i < 9; i++) m.a[i] = '0;
    m.a[0] = d0; m.a[4] = d1; m.a[8] = d2;
    m.t = '{tx, ty, tz};
    return m;
  endfunction

  function automatic matrix_t fill_matrix(word_t v);
    matrix_t m;
    for (int i = 0; i < 9; i++) m.a[i] = v;
    m.t = '{v, v, v};
    return m;
  endfunction

  function automatic word_t small_val(int lim);
    return word_t'(int'($urandom_range(2 * lim)) - lim);
  endfunction

  // Mostly well-conditioned matrices, with singular and raw-bit noise mixed in.
  function automatic matrix_t random_matrix();
    matrix_t m;
    int kind;
    kind = $urandom_range(99);
    for (int i = 0; i < 9; i++) m.a[i] = small_val(4 * 65536);
    for (int i = 0; i < 3; i++) m.t[i] = small_val(64 * 65536);
    if (kind < 55) begin
      for (int i = 0; i < 3; i++) m.a[i*4] = m.a[i*4] + word_t'(6 * 65536);
    end else if (kind < 70) begin
      for (int i = 0; i < 9; i++) m.a[i] = word_t'($urandom());
      for (int i = 0; i < 3; i++) m.t[i] = word_t'($urandom());
    end else if (kind < 80) begin
      for (int j = 0; j < 3; j++) m.a[6+j] = m.a[j];
    end else if (kind < 90) begin
      // Tiny entries give determinants around the threshold.
      for (int i = 0; i < 9; i++) m.a[i] = small_val(600);
      for (int i = 0; i < 3; i++) m.a[i*4] = small_val(30000);
    end else begin
      for (int i = 0; i < 9; i++) m.a[i] = small_val(40000 * 65536);
    end
    return m;
  endfunction

  // ---------------------------------------------------------------- receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      out_ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_go) begin
      out_ready <= 1'b0;
      hold_cnt <= HoldLen;
      hold_go <= 1'b0;
    end else begin
      out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 12);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (rows_due.size() == 0) begin
        $display("%0t: unexpected row word row=%0d x=%h y=%h z=%h", $time,
                 row_index, col_x, col_y, col_z);
        errors++;
      end else begin
        row_word_t r;
        r = rows_due.pop_front();
        if (row_index !== r.row) begin
          $display("%0t: row_index expected %0d actual %0d", $time, r.row, row_index);
          errors++;
        end
        if (col_x !== r.x) begin
          $display("%0t: col_x row %0d expected %h actual %h", $time, r.row, r.x, col_x);
          errors++;
        end
        if (col_y !== r.y) begin
          $display("%0t: col_y row %0d expected %h actual %h", $time, r.row, r.y, col_y);
          errors++;
        end
        if (col_z !== r.z) begin
          $display("%0t: col_z row %0d expected %h actual %h", $time, r.row, r.z, col_z);
          errors++;
        end
        if (singular !== r.sing) begin
          $display("%0t: singular row %0d expected %b actual %b", $time, r.row, r.sing,
                   singular);
          errors++;
        end
        if (last_row !== r.last) begin
          $display("%0t: last_row row %0d expected %b actual %b", $time, r.row, r.last,
                   last_row);
          errors++;
        end
      end
    end
  end

  // Ends a run that has stopped moving.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      wdog <= 0;
    end else if (wdog >= WdogMax) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      wdog <= wdog + 1;
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    matrix_t m;
    send_matrix(diag_matrix(QOne, QOne, QOne, 0, 0, 0));
    send_matrix(diag_matrix(2 * QOne, 2 * QOne, 2 * QOne, 3 * QOne, -5 * QOne, 32768));
    send_matrix(diag_matrix(32768, -QOne, 4 * QOne, 7, -7, 100));
    send_matrix(diag_matrix(QOne, QOne, QOne, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
    send_matrix(diag_matrix(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, QOne, QOne, QOne));
    send_matrix(diag_matrix(32'h80000000, 32'h80000000, 32'h80000000, -QOne, 1, -1));
    send_matrix(diag_matrix(1, 1, 1, QOne, QOne, QOne));
    send_matrix(fill_matrix('0));
    send_matrix(fill_matrix(32'h7fffffff));
    send_matrix(fill_matrix(32'h80000000));
    send_matrix(fill_matrix(32'hffffffff));
    // A row permutation gives a negative determinant.
    m = diag_matrix(0, 0, 0, QOne, 2 * QOne, 3 * QOne);
    m.a[1] = QOne; m.a[3] = QOne; m.a[8] = QOne;
    send_matrix(m);
    m = diag_matrix(QOne, QOne, QOne, 0, 0, 0);
    m.a[1] = 3 * QOne; m.a[5] = -2 * QOne; m.a[6] = 32768;
    send_matrix(m);
    send_matrix(diag_matrix(32'h00010000, 32'h7fffffff, 32'h00000100, 32'h80000000,
                            32'h80000000, 32'h80000000));
  endtask

  task automatic test_threshold();
    set_threshold(17'd65536);
    send_matrix(diag_matrix(65535, QOne, QOne, QOne, 0, 0));
    send_matrix(diag_matrix(65536, QOne, QOne, QOne, 0, 0));
    send_matrix(diag_matrix(-65536, QOne, QOne, 0, QOne, 0));
    set_threshold(17'd0);
    send_matrix(diag_matrix(1, QOne, QOne, QOne, QOne, QOne));
    send_matrix(fill_matrix(QOne));
    set_threshold(17'h1ffff);
    send_matrix(diag_matrix(131070, QOne, QOne, 0, 0, QOne));
    send_matrix(diag_matrix(-131071, QOne, QOne, 0, 0, QOne));
    set_threshold(17'd7);
    send_matrix(diag_matrix(6, QOne, QOne, 0, 0, 0));
    send_matrix(diag_matrix(7, QOne, QOne, 0, 0, 0));
  endtask

  task automatic test_backpressure();
    hold_go = 1'b1;
    repeat (40) send_matrix(random_matrix());
  endtask

  task automatic test_pause();
    repeat (10) send_matrix(random_matrix());
    stop_sending();
    wait_drained();
    repeat (10) send_matrix(random_matrix());
  endtask

  task automatic test_random(input int count);
    for (int n = 0; n < count; n++) begin
      no_idle = (n >= count / 3) && (n < count / 3 + 60);
      send_matrix(random_matrix());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_threshold();
    test_backpressure();
    test_pause();
    test_random(120);
    set_threshold(17'($urandom_range(65536)));
    test_random(60);
    set_threshold(17'd7);
    test_random(80);
    stop_sending();
    wait_drained();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
